>>> rtl/bezier_curve_table_evaluator_defines.svh
// assertion macros for the bezier curve table evaluator
`ifndef BEZIER_CURVE_TABLE_EVALUATOR_DEFINES_SVH
`define BEZIER_CURVE_TABLE_EVALUATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BCTE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BCTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bcte_pkg.sv
// types, codes and helpers for the bezier curve table evaluator
`timescale 1ns / 1ps

package bcte_pkg;

    localparam int DATA_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [DATA_W-1:0] Q_ONE = 16'sd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_Y = 3'd0,
        REG_CTRL1_X = 3'd1,
        REG_CTRL1_Y = 3'd2,
        REG_CTRL2_X = 3'd3,
        REG_CTRL2_Y = 3'd4,
        REG_END_Y   = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        CMD_BUILD = 1'b0,
        CMD_EVAL  = 1'b1
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_B_W1,
        S_B_W2,
        S_B_ACC,
        S_DIV_LD,
        S_DIV,
        S_RC_MUL,
        S_RC_CHK,
        S_RC_FIX,
        S_DIV_END,
        S_POST,
        S_EV_SCAN,
        S_EV_MUL,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        CTX_BX,
        CTX_BY,
        CTX_EV
    } div_ctx_t;

    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 64'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -64'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/bezier_curve_table_evaluator.sv
// cubic bezier curve sample table with linear interpolation lookup
//
//  channel   signals                                   direction
//  s_        s_valid s_ready s_cmd s_x_value          command in
//  m_        m_valid m_ready m_y_value m_not_ready    result out
//  cfg_      cfg_valid cfg_ready cfg_index cfg_data   register write
//
// one command at a time. evaluate: the time from accept to result is set by the sample
// scan over the table memories and the bit-serial divider (36-bit divide for the default
// table). build: two divides per sample by (TABLE_POINTS-1)^3, done by a reciprocal
// multiply and one correction step. no clearing pass after reset. a result that is not
// taken holds the sequencer in its done state.
`timescale 1ns / 1ps
`include "bezier_curve_table_evaluator_defines.svh"

module bezier_curve_table_evaluator import bcte_pkg::*; #(
    parameter int TABLE_POINTS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_cmd,
    input  logic signed [DATA_W-1:0]     s_x_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_W-1:0]     m_y_value,
    output logic                         m_not_ready,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [DATA_W-1:0]            cfg_data
);

    localparam int AW    = $clog2(TABLE_POINTS);
    localparam int LASTI = TABLE_POINTS - 1;
    localparam int D3    = LASTI * LASTI * LASTI;
    localparam int WW    = 3 * AW;
    localparam int ACC_W = WW + 19;
    localparam int NUM_W = (ACC_W > 36) ? ACC_W : 36;
    localparam int DEN_W = (WW > 17) ? WW : 17;
    localparam int CNT_W = $clog2(NUM_W);
    // numerator magnitude stays below 2^16 * D3, so below 2^RC_SH
    localparam int RC_SH = $clog2(D3 + 1) + 16;
    localparam int RC_W  = 18;
    localparam int QE_W  = 18;
    localparam logic [AW-1:0]           LAST    = AW'(LASTI);
    localparam logic [AW:0]             NPTS    = (AW+1)'(TABLE_POINTS);
    localparam logic signed [NUM_W-1:0] HALF_D3 = NUM_W'(D3 / 2);
    localparam logic [DEN_W-1:0]        DEN_D3  = DEN_W'(D3);
    localparam logic [CNT_W-1:0]        CNT_TOP = CNT_W'(NUM_W - 1);
    localparam logic [RC_W-1:0]         RC_M    = RC_W'((64'd1 << RC_SH) / 64'(D3));
    localparam logic [NUM_W-1:0]        D3_N    = NUM_W'(D3);

    state_t   state_reg, state_next;
    div_ctx_t ctx_reg;

    logic signed [DATA_W-1:0] start_y_reg, ctrl1_x_reg, ctrl1_y_reg;
    logic signed [DATA_W-1:0] ctrl2_x_reg, ctrl2_y_reg, end_y_reg;
    logic                     built_reg;

    // build sequencing
    logic [AW-1:0]             bi_reg;
    logic [2*AW-1:0]           uu_reg, vv_reg, uv_reg;
    logic [WW-1:0]             w_reg [4];
    logic [1:0]                k_reg;
    logic signed [ACC_W-1:0]   acc_x_reg, acc_y_reg;
    logic signed [DATA_W-1:0]  sx_hold_reg;

    // evaluate sequencing
    logic signed [DATA_W-1:0]  x_in_reg;
    logic [AW:0]               ra_reg;
    logic                      dv_reg;
    logic [AW-1:0]             di_reg;
    logic signed [DATA_W-1:0]  px_reg, py_reg;
    logic signed [DATA_W-1:0]  x0_reg, y0_reg, x1_reg, y1_reg;
    logic signed [33:0]        prod_reg;

    // divider
    logic [DEN_W-1:0]          den_reg;
    logic [NUM_W-1:0]          dq_reg;
    logic [DEN_W:0]            rem_reg;
    logic                      neg_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic signed [NUM_W:0]     q_reg;
    logic [QE_W-1:0]           qe_reg;
    logic [NUM_W-1:0]          qd_reg;

    logic signed [DATA_W-1:0]  res_y_reg;
    logic                      res_nr_reg;
    logic                      m_valid_reg;
    logic signed [DATA_W-1:0]  m_y_reg;
    logic                      m_nr_reg;

    // table memories
    logic signed [DATA_W-1:0]  mem_x [TABLE_POINTS];
    logic signed [DATA_W-1:0]  mem_y [TABLE_POINTS];
    logic signed [DATA_W-1:0]  rd_x_reg, rd_y_reg;

    logic                      s_fire, m_fire, mem_we, issue;
    logic [AW-1:0]             v_idx;
    logic signed [NUM_W-1:0]   num_sel;
    logic [NUM_W-1:0]          num_mag;
    logic [DEN_W:0]            rem_sh, rem_new;
    logic                      ge;
    logic [NUM_W:0]            qm;
    logic [RC_SH+RC_W-1:0]     rc_prod;
    logic [NUM_W-1:0]          rc_rem;
    logic signed [NUM_W+1:0]   ev_sum;
    logic signed [DATA_W-1:0]  post_sat, ev_sat;
    logic signed [DATA_W:0]    cx_sel, cy_sel;
    logic signed [WW:0]        w_sel;

    assign s_ready     = (state_reg == S_IDLE);
    assign s_fire      = s_valid && s_ready;
    assign m_valid     = m_valid_reg;
    assign m_y_value   = m_y_reg;
    assign m_not_ready = m_nr_reg;
    assign m_fire      = m_valid_reg && m_ready;
    assign cfg_ready   = 1'b1;

    assign mem_we = (state_reg == S_POST) && (ctx_reg == CTX_BY);
    assign issue  = (state_reg == S_EV_SCAN) && (ra_reg < NPTS);
    assign v_idx  = LAST - bi_reg;

    // divider step, one quotient bit a cycle
    assign rem_sh  = {rem_reg[DEN_W-1:0], dq_reg[NUM_W-1]};
    assign ge      = (rem_sh >= {1'b0, den_reg});
    assign rem_new = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
    assign qm      = {1'b0, dq_reg} + (NUM_W+1)'(neg_reg && (rem_reg != '0));

    // quotient estimate by D3 is low by at most one
    assign rc_prod = (RC_SH+RC_W)'(dq_reg[RC_SH-1:0]) * (RC_SH+RC_W)'(RC_M);
    assign rc_rem  = dq_reg - qd_reg;

    always_comb begin
        case (ctx_reg)
            CTX_BX:  num_sel = NUM_W'(acc_x_reg) + HALF_D3;
            CTX_BY:  num_sel = NUM_W'(acc_y_reg) + HALF_D3;
            default: num_sel = NUM_W'(prod_reg) + NUM_W'(den_reg >> 1);
        endcase
        num_mag = num_sel[NUM_W-1] ? NUM_W'(-num_sel) : NUM_W'(num_sel);
    end

    assign post_sat = sat16(64'(q_reg));
    assign ev_sum   = (NUM_W+2)'(y0_reg) + (NUM_W+2)'(q_reg);
    assign ev_sat   = sat16(64'(ev_sum));

    // bernstein term selection for the accumulate step
    always_comb begin
        w_sel = $signed({1'b0, w_reg[k_reg]});
        case (k_reg)
            2'd0: begin
                cx_sel = '0;
                cy_sel = (DATA_W+1)'(start_y_reg);
            end
            2'd1: begin
                cx_sel = (DATA_W+1)'(ctrl1_x_reg);
                cy_sel = (DATA_W+1)'(ctrl1_y_reg);
            end
            2'd2: begin
                cx_sel = (DATA_W+1)'(ctrl2_x_reg);
                cy_sel = (DATA_W+1)'(ctrl2_y_reg);
            end
            default: begin
                cx_sel = (DATA_W+1)'(Q_ONE);
                cy_sel = (DATA_W+1)'(end_y_reg);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_x[bi_reg] <= sx_hold_reg;
            mem_y[bi_reg] <= post_sat;
        end
        rd_x_reg <= mem_x[ra_reg[AW-1:0]];
        rd_y_reg <= mem_y[ra_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (cmd_t'(s_cmd) == CMD_BUILD) begin
                        state_next = S_B_W1;
                    end else if (!built_reg) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_EV_SCAN;
                    end
                end
            end
            S_B_W1:    state_next = S_B_W2;
            S_B_W2:    state_next = S_B_ACC;
            S_B_ACC: begin
                if (k_reg == 2'd3) begin
                    state_next = S_DIV_LD;
                end
            end
            S_DIV_LD:  state_next = (ctx_reg == CTX_EV) ? S_DIV : S_RC_MUL;
            S_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = S_DIV_END;
                end
            end
            S_RC_MUL:  state_next = S_RC_CHK;
            S_RC_CHK:  state_next = S_RC_FIX;
            S_RC_FIX:  state_next = S_DIV_END;
            S_DIV_END: state_next = S_POST;
            S_POST: begin
                unique case (ctx_reg)
                    CTX_BX: state_next = S_DIV_LD;
                    CTX_BY: state_next = (bi_reg == LAST) ? S_DONE : S_B_W1;
                    default: state_next = S_DONE;
                endcase
            end
            S_EV_SCAN: begin
                if (dv_reg) begin
                    if (di_reg == '0) begin
                        if (x_in_reg <= 0 || x_in_reg < rd_x_reg) begin
                            state_next = S_DONE;
                        end
                    end else if (x_in_reg < rd_x_reg) begin
                        state_next = S_EV_MUL;
                    end else if (di_reg == LAST) begin
                        state_next = S_DONE;
                    end
                end
            end
            S_EV_MUL:  state_next = S_DIV_LD;
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_y_reg <= '0;
            ctrl1_x_reg <= '0;
            ctrl1_y_reg <= '0;
            ctrl2_x_reg <= Q_ONE;
            ctrl2_y_reg <= Q_ONE;
            end_y_reg   <= Q_ONE;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_START_Y: start_y_reg <= cfg_data;
                REG_CTRL1_X: ctrl1_x_reg <= cfg_data;
                REG_CTRL1_Y: ctrl1_y_reg <= cfg_data;
                REG_CTRL2_X: ctrl2_x_reg <= cfg_data;
                REG_CTRL2_Y: ctrl2_y_reg <= cfg_data;
                REG_END_Y:   end_y_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // control flags and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            built_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            dv_reg      <= 1'b0;
        end else begin
            dv_reg <= issue;
            if (mem_we && bi_reg == LAST) begin
                built_reg <= 1'b1;
            end
            if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_fire) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
            m_y_reg  <= res_y_reg;
            m_nr_reg <= res_nr_reg;
        end
        di_reg <= ra_reg[AW-1:0];
        if (issue) begin
            ra_reg <= ra_reg + 1'b1;
        end
        case (state_reg)
            S_IDLE: begin
                x_in_reg   <= s_x_value;
                bi_reg     <= '0;
                ra_reg     <= '0;
                res_y_reg  <= '0;
                res_nr_reg <= (cmd_t'(s_cmd) == CMD_EVAL) && !built_reg;
                ctx_reg    <= (cmd_t'(s_cmd) == CMD_BUILD) ? CTX_BX : CTX_EV;
            end
            S_B_W1: begin
                uu_reg  <= (2*AW)'(bi_reg) * (2*AW)'(bi_reg);
                vv_reg  <= (2*AW)'(v_idx) * (2*AW)'(v_idx);
                uv_reg  <= (2*AW)'(bi_reg) * (2*AW)'(v_idx);
                ctx_reg <= CTX_BX;
            end
            S_B_W2: begin
                w_reg[0]  <= WW'(vv_reg) * WW'(v_idx);
                w_reg[1]  <= WW'(uv_reg) * WW'(v_idx) * WW'(3);
                w_reg[2]  <= WW'(uv_reg) * WW'(bi_reg) * WW'(3);
                w_reg[3]  <= WW'(uu_reg) * WW'(bi_reg);
                k_reg     <= '0;
                acc_x_reg <= '0;
                acc_y_reg <= '0;
            end
            S_B_ACC: begin
                acc_x_reg <= acc_x_reg + ACC_W'(w_sel * cx_sel);
                acc_y_reg <= acc_y_reg + ACC_W'(w_sel * cy_sel);
                k_reg     <= k_reg + 2'd1;
                den_reg   <= DEN_D3;
            end
            S_DIV_LD: begin
                dq_reg  <= num_mag;
                neg_reg <= num_sel[NUM_W-1];
                rem_reg <= '0;
                cnt_reg <= CNT_TOP;
            end
            S_DIV: begin
                dq_reg  <= {dq_reg[NUM_W-2:0], ge};
                rem_reg <= rem_new;
                cnt_reg <= cnt_reg - 1'b1;
            end
            S_RC_MUL: begin
                qe_reg <= QE_W'(rc_prod >> RC_SH);
            end
            S_RC_CHK: begin
                qd_reg <= NUM_W'(qe_reg) * D3_N;
            end
            S_RC_FIX: begin
                if (rc_rem >= D3_N) begin
                    dq_reg  <= NUM_W'(qe_reg) + 1'b1;
                    rem_reg <= (DEN_W+1)'(rc_rem - D3_N);
                end else begin
                    dq_reg  <= NUM_W'(qe_reg);
                    rem_reg <= (DEN_W+1)'(rc_rem);
                end
            end
            S_DIV_END: begin
                q_reg <= neg_reg ? -$signed(qm) : $signed(qm);
            end
            S_POST: begin
                case (ctx_reg)
                    CTX_BX: begin
                        sx_hold_reg <= post_sat;
                        ctx_reg     <= CTX_BY;
                    end
                    CTX_BY: begin
                        bi_reg    <= bi_reg + 1'b1;
                        res_y_reg <= '0;
                    end
                    default: res_y_reg <= ev_sat;
                endcase
            end
            S_EV_SCAN: begin
                if (dv_reg) begin
                    px_reg    <= rd_x_reg;
                    py_reg    <= rd_y_reg;
                    res_y_reg <= rd_y_reg;
                    x0_reg    <= px_reg;
                    y0_reg    <= py_reg;
                    x1_reg    <= rd_x_reg;
                    y1_reg    <= rd_y_reg;
                end
            end
            S_EV_MUL: begin
                prod_reg <= (x_in_reg - x0_reg) * (y1_reg - y0_reg);
                den_reg  <= DEN_W'(x1_reg - x0_reg);
            end
            default: ;
        endcase
    end

    `BCTE_ASSERT_NOW(a_we_in_build, mem_we, ctx_reg == CTX_BY && state_reg == S_POST, "table write outside build")
    `BCTE_ASSERT_NOW(a_nr_unbuilt, m_valid_reg && m_nr_reg && state_reg == S_IDLE, !built_reg, "not_ready after build")
    `BCTE_ASSERT_NEXT(a_eval_scan, s_fire && s_cmd && built_reg, state_reg == S_EV_SCAN && !dv_reg, "evaluate did not start scan")
    `BCTE_ASSERT_NOW(a_busy_no_ready, state_reg != S_IDLE, !s_ready, "command taken while busy")

endmodule

>>> bench/tb_bezier_curve_table_evaluator.sv
// self-checking bench for the bezier curve table evaluator: random commands, config sweeps
`timescale 1ns / 1ps

module tb_bezier_curve_table_evaluator import bcte_pkg::*;;

    localparam int NPTS = 32;
    localparam int CLK_HALF = 6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct {
        cmd_t               cmd;
        logic signed [15:0] x;
    } curve_cmd_t;

    typedef struct {
        logic signed [15:0] y;
        logic               nr;
    } curve_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_cmd = 1'b0;
    logic signed [DATA_W-1:0] s_x_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [DATA_W-1:0] m_y_value;
    logic m_not_ready;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;

    bezier_curve_table_evaluator #(.TABLE_POINTS(NPTS)) DUT (.*);

    always #(CLK_HALF) aclk = ~aclk;

    // predictor state
    logic signed [15:0] reg_file [6];
    logic signed [15:0] tbl_x [NPTS];
    logic signed [15:0] tbl_y [NPTS];
    bit table_ok;

    curve_cmd_t pending_cmds[$];
    curve_res_t expected_res[$];
    int n_queued = 0;
    int n_taken = 0;
    int n_errors = 0;
    bit run_started = 0;
    bit no_idle = 0;
    bit hold_req = 0;
    bit s_took = 0;
    int hold_cnt = 0;

    function automatic longint round_div(longint num, longint den);
        longint n, q;
        n = num + den / 2;
        q = n / den;
        if ((n % den) != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    task automatic build_samples();
        longint d, d3, u, v, w0, w1, w2, w3, nx, ny;
        d = NPTS - 1;
        d3 = d * d * d;
        for (int i = 0; i < NPTS; i++) begin
            u = i;
            v = d - i;
            w0 = v * v * v;
            w1 = 3 * u * v * v;
            w2 = 3 * u * u * v;
            w3 = u * u * u;
            nx = w1 * longint'(reg_file[REG_CTRL1_X]) + w2 * longint'(reg_file[REG_CTRL2_X])
                 + w3 * 16384;
            ny = w0 * longint'(reg_file[REG_START_Y]) + w1 * longint'(reg_file[REG_CTRL1_Y])
                 + w2 * longint'(reg_file[REG_CTRL2_Y]) + w3 * longint'(reg_file[REG_END_Y]);
            tbl_x[i] = clip16(round_div(nx, d3));
            tbl_y[i] = clip16(round_div(ny, d3));
        end
        table_ok = 1;
    endtask

    function automatic logic signed [15:0] interp_curve(logic signed [15:0] x);
        longint x0, x1, y0, y1;
        if (x <= 0 || x < tbl_x[0]) return tbl_y[0];
        for (int i = 1; i < NPTS; i++) begin
            if (x < tbl_x[i]) begin
                x0 = tbl_x[i-1];
                x1 = tbl_x[i];
                y0 = tbl_y[i-1];
                y1 = tbl_y[i];
                if (x1 - x0 <= 0) return tbl_y[i-1];
                return clip16(y0 + round_div((longint'(x) - x0) * (y1 - y0), x1 - x0));
            end
        end
        return tbl_y[NPTS-1];
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // monitor: prediction on accepted commands, checking on accepted results
    always @(posedge aclk) begin
        curve_res_t r;
        s_took <= s_valid && s_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready && cfg_index < 6) reg_file[cfg_index] = cfg_data;
            if (s_valid && s_ready) begin
                n_taken++;
                if (cmd_t'(s_cmd) == CMD_BUILD) begin
                    build_samples();
                    r.y = '0;
                    r.nr = 1'b0;
                end else if (!table_ok) begin
                    r.y = '0;
                    r.nr = 1'b1;
                end else begin
                    r.y = interp_curve(s_x_value);
                    r.nr = 1'b0;
                end
                expected_res.push_back(r);
            end
            if (m_valid && m_ready) begin
                if (expected_res.size() == 0) begin
                    report_mismatch("unexpected transaction", 1, 0);
                end else begin
                    r = expected_res.pop_front();
                    if (m_y_value !== r.y) report_mismatch("y_value", m_y_value, r.y);
                    if (m_not_ready !== r.nr) report_mismatch("not_ready", m_not_ready, r.nr);
                end
            end
        end
    end

    // command driver
    always @(negedge aclk) begin
        curve_cmd_t c;
        if (run_started && (!s_valid || s_took)) begin
            if (pending_cmds.size() > 0 && (no_idle || $urandom_range(0, 99) >= 25)) begin
                c = pending_cmds.pop_front();
                s_valid <= 1'b1;
                s_cmd <= c.cmd;
                s_x_value <= c.x;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver, with an occasional long hold-off that outlasts a table build
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_cnt = 1500;
        end
        if (!run_started) begin
            m_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_idle || ($urandom_range(0, 99) >= 25);
        end
    end

    task automatic push_cmd(cmd_t c, logic signed [15:0] x);
        curve_cmd_t it;
        it.cmd = c;
        it.x = x;
        pending_cmds.push_back(it);
        n_queued++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (n_taken != n_queued || expected_res.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic random_x_cmd();
        if ($urandom_range(0, 99) < 60)
            push_cmd(CMD_EVAL, 16'($urandom_range(0, 16500)));
        else
            push_cmd(CMD_EVAL, 16'($urandom()));
    endtask

    initial begin
        logic [15:0] vals [6];
        for (int i = 0; i < 6; i++) reg_file[i] = '0;
        reg_file[REG_CTRL2_X] = Q_ONE;
        reg_file[REG_CTRL2_Y] = Q_ONE;
        reg_file[REG_END_Y] = Q_ONE;
        for (int i = 0; i < NPTS; i++) begin
            tbl_x[i] = '0;
            tbl_y[i] = '0;
        end
        table_ok = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        run_started = 1;

        // evaluate before any build, then the reset curve
        push_cmd(CMD_EVAL, 16'sd0);
        push_cmd(CMD_EVAL, 16'sh7fff);
        push_cmd(CMD_EVAL, 16'sh8000);
        push_cmd(CMD_BUILD, 16'sh7fff);
        push_cmd(CMD_EVAL, 16'sd0);
        push_cmd(CMD_EVAL, -16'sd1);
        push_cmd(CMD_EVAL, 16'sh8000);
        push_cmd(CMD_EVAL, 16'sd1);
        push_cmd(CMD_EVAL, 16'sd8192);
        push_cmd(CMD_EVAL, 16'sd16383);
        push_cmd(CMD_EVAL, 16'sd16384);
        push_cmd(CMD_EVAL, 16'sh7fff);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            for (int k = 0; k < 6; k++) begin
                case (ph)
                    0: vals[k] = 16'h7fff;
                    1: vals[k] = 16'h8000;
                    2, 3: vals[k] = 16'($urandom_range(0, 16384));
                    default: vals[k] = 16'($urandom());
                endcase
            end
            // second sample x well above zero so that low inputs land before it
            if (ph == 4) vals[REG_CTRL1_X] = 16'h7fff;
            for (int k = 0; k < 6; k++) write_reg(k[CFG_IDX_W-1:0], vals[k]);
            write_reg(REG_SPARE_6, 16'($urandom()));
            write_reg(REG_SPARE_7, 16'($urandom()));
            no_idle = (ph == 2);
            if (ph == 3) hold_req = 1;
            push_cmd(CMD_BUILD, 16'($urandom()));
            if (ph == 4) begin
                push_cmd(CMD_EVAL, 16'sd1);
                push_cmd(CMD_EVAL, 16'sd100);
            end
            for (int n = 0; n < 38; n++) begin
                if ($urandom_range(0, 99) < 3) push_cmd(CMD_BUILD, 16'($urandom()));
                else random_x_cmd();
            end
            drain();
            no_idle = 0;
        end

        repeat (100) @(posedge aclk);
        if (n_errors == 0 && expected_res.size() == 0) begin
            $display("tb_bezier_curve_table_evaluator: PASS");
        end else begin
            if (expected_res.size() != 0) report_mismatch("leftover", expected_res.size(), 0);
            $display("tb_bezier_curve_table_evaluator: FAIL");
        end
        $finish;
    end

    initial begin
        #(64'd1000000 * 2 * CLK_HALF);
        $display("tb_bezier_curve_table_evaluator: FAIL");
        $finish;
    end

endmodule
